[sv/scbc_pkg.sv]
// Shared constants, types and helpers for the sphere/convex-block contact unit.
// No dependencies.
package scbc_pkg;

    localparam int RADIUS_W = 31;
    localparam int FRIC_W   = 10;
    localparam int STIFF_W  = 16;
    localparam int GTHR_W   = 15;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_FRIC   = 2'd1;
    localparam logic [1:0] REG_STIFF  = 2'd2;
    localparam logic [1:0] REG_GTHR   = 2'd3;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [FRIC_W-1:0]   FRIC_RST   = 10'd10;
    localparam logic [STIFF_W-1:0]  STIFF_RST  = 16'd1000;
    localparam logic [GTHR_W-1:0]   GTHR_RST   = 15'd8192;

    localparam int CFG_IDX_W = 2;
    localparam int SQRT_STEPS = 32;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;  // store body, begin block
    localparam logic [3:0] OP_PROD  = 4'd2;  // products n*p of nearest point
    localparam logic [3:0] OP_DIST  = 4'd3;  // sum and round distance
    localparam logic [3:0] OP_CPROD = 4'd4;  // products n*d
    localparam logic [3:0] OP_UPD   = 4'd5;  // update nearest, deepest
    localparam logic [3:0] OP_DIFF  = 4'd6;  // body minus nearest
    localparam logic [3:0] OP_SQ    = 4'd7;  // squares
    localparam logic [3:0] OP_SQRT  = 4'd8;  // one root step
    localparam logic [3:0] OP_INP   = 4'd9;  // inside products
    localparam logic [3:0] OP_INS   = 4'd10; // inside distance
    localparam logic [3:0] OP_DIV   = 4'd11; // one divide step, all axes
    localparam logic [3:0] OP_DEPTH = 4'd12; // depth product
    localparam logic [3:0] OP_PUSH  = 4'd13; // push and friction products
    localparam logic [3:0] OP_ACC   = 4'd14; // final sums

    typedef struct packed {
        logic [3:0] op;
        logic       first;   // first step of an iteration
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic step_done;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)       sat32 = 32'sh7fffffff;
        else if (x < -64'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = x[31:0];
    endfunction

    // round right by 14, ties toward plus infinity
    function automatic logic signed [63:0] rsh14(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + 64'sd8192;
        rsh14 = t >>> 14;
    endfunction

endpackage

[sv/sphere_convex_block_contact.sv]
// Top level of the sphere/convex-block contact unit: ports, registers, output stage.
// Depends on scbc_pkg, scbc_ctrl, scbc_dp.
//
//  channel   dir  handshake                 content
//  s_axis    in   s_axis_tvalid/tready      item: func in tuser, wall mark in tlast
//  m_axis    out  m_axis_tvalid/tready      result: contact, grounded, accelerations
//  cfg       in   i_cfg_valid/o_cfg_ready   register index and value
//
// A wall runs the product, distance, n*d and update steps; the last wall then also
// runs the root and the shared divide, or the inside distance when the body sits inside.
// Reset is synchronous and restores register defaults and an empty block.
// A result held in the output register stalls only the final step of the next block.
module sphere_convex_block_contact
    import scbc_pkg::*;
#(
    parameter int P_CFG_IDX_W = CFG_IDX_W
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: pos_x,pos_y,pos_z,vel_x,vel_y,vel_z,normal_x,normal_y,normal_z,plane_offset
    input  logic [271:0]           s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   s_axis_tuser,    // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: grounded, accel_x, accel_y, accel_z, zero fill
    output logic [103:0]           m_axis_tdata,
    output logic                   m_axis_tuser,    // contact
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [P_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    logic [RADIUS_W-1:0] r_radius;
    logic [FRIC_W-1:0]   r_fric;
    logic [STIFF_W-1:0]  r_stiff;
    logic [GTHR_W-1:0]   r_gthr;

    logic signed [31:0] pos [3], vel [3], acc [3];
    logic signed [15:0] nrm [3];
    logic  contact, ground, res_load, rdy;
    t_cmd  cmd;
    t_stat stat;
    logic  r_ovalid;
    logic [103:0] r_odata;
    logic  r_ouser;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST; r_fric <= FRIC_RST;
            r_stiff <= STIFF_RST;   r_gthr <= GTHR_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == P_CFG_IDX_W'(REG_RADIUS)) r_radius <= i_cfg_data[RADIUS_W-1:0];
            if (i_cfg_index == P_CFG_IDX_W'(REG_FRIC))   r_fric   <= i_cfg_data[FRIC_W-1:0];
            if (i_cfg_index == P_CFG_IDX_W'(REG_STIFF))  r_stiff  <= i_cfg_data[STIFF_W-1:0];
            if (i_cfg_index == P_CFG_IDX_W'(REG_GTHR))   r_gthr   <= i_cfg_data[GTHR_W-1:0];
        end
    end

    // unpack
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos[k] = s_axis_tdata[32*k +: 32];
            vel[k] = s_axis_tdata[96 + 32*k +: 32];
            nrm[k] = s_axis_tdata[192 + 16*k +: 16];
        end
    end

    assign s_axis_tready = rdy;

    scbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_func(s_axis_tuser), .i_last(s_axis_tlast), .o_in_ready(rdy),
        .o_res_load(res_load), .i_res_busy(r_ovalid && !m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    scbc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_pos(pos), .i_vel(vel), .i_nrm(nrm), .i_off(s_axis_tdata[271:240]),
        .i_radius(r_radius), .i_fric(r_fric), .i_stiff(r_stiff), .i_gthr(r_gthr),
        .o_contact(contact), .o_ground(ground), .o_acc(acc)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_load) begin
            r_ovalid <= 1'b1;
            r_ouser  <= contact;
            r_odata  <= {7'd0, acc[2], acc[1], acc[0], ground};
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule

[sv/scbc_ctrl.sv]
// Sequencer of the contact unit: walks load, wall and final phases.
// Depends on scbc_pkg.
module scbc_ctrl
    import scbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_func,
    input  logic  i_last,
    output logic  o_in_ready,
    output logic  o_res_load,
    input  logic  i_res_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIST  = 4'd1;
    localparam logic [3:0] S_CPROD = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_BR    = 4'd7;
    localparam logic [3:0] S_INS   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DEPTH = 4'd10;
    localparam logic [3:0] S_PUSH  = 4'd11;
    localparam logic [3:0] S_ACC   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_first, n_first;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_first = 1'b0;
        o_cmd.op = OP_NONE;
        o_cmd.first = r_first;
        o_res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_func) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_PROD;
                        n_last = i_last;
                        n_state = S_DIST;
                    end
                end
            end
            S_DIST:  begin o_cmd.op = OP_DIST;  n_state = S_CPROD; end
            S_CPROD: begin o_cmd.op = OP_CPROD; n_state = S_UPD; end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                n_state = r_last ? S_DIFF : S_IDLE;
            end
            S_DIFF: begin o_cmd.op = OP_DIFF; n_state = S_SQ; end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state = S_SQRT;
                n_first = 1'b1;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_stat.step_done) n_state = S_BR;
            end
            S_BR: begin
                if (i_stat.len_zero) begin
                    o_cmd.op = OP_INP;
                    n_state = S_INS;
                end else begin
                    n_state = S_DIV;
                    n_first = 1'b1;
                end
            end
            S_INS: begin o_cmd.op = OP_INS; n_state = S_DEPTH; end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.step_done) n_state = S_DEPTH;
            end
            S_DEPTH: begin o_cmd.op = OP_DEPTH; n_state = S_PUSH; end
            S_PUSH:  begin o_cmd.op = OP_PUSH;  n_state = S_ACC; end
            S_ACC:   begin o_cmd.op = OP_ACC;   n_state = S_OUT; end
            S_OUT: begin
                // hold until the output register is free
                if (!i_res_busy) begin
                    o_res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_first <= n_first;
        end
    end
endmodule

[sv/scbc_dp.sv]
// Datapath of the contact unit: state, products, root and divide iterations.
// Depends on scbc_pkg.
module scbc_dp
    import scbc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic signed [31:0]         i_pos [3],
    input  logic signed [31:0]         i_vel [3],
    input  logic signed [15:0]         i_nrm [3],
    input  logic signed [31:0]         i_off,
    input  logic [RADIUS_W-1:0]        i_radius,
    input  logic [FRIC_W-1:0]          i_fric,
    input  logic [STIFF_W-1:0]         i_stiff,
    input  logic [GTHR_W-1:0]          i_gthr,
    output logic                       o_contact,
    output logic                       o_ground,
    output logic signed [31:0]         o_acc [3]
);
    logic signed [31:0] r_body [3];
    logic signed [31:0] r_bvel [3];
    logic signed [31:0] r_near [3];
    logic signed [31:0] r_deep_d;
    logic signed [15:0] r_deep_n [3];
    logic signed [31:0] r_deep_o;
    logic               r_seen;
    logic signed [15:0] r_n [3];
    logic signed [31:0] r_off;
    logic signed [47:0] r_prod [3];
    logic signed [31:0] r_d;
    logic signed [31:0] r_diff [3];
    logic [63:0]        r_sq [3];
    logic [63:0]        r_rem, r_root;
    logic [5:0]         r_cnt;
    logic signed [32:0] r_lv;
    logic [31:0]        r_len;
    logic [46:0]        r_nrem [3];   // divide remainders on |diff|*2^14
    logic [46:0]        r_q [3];
    logic [47:0]        r_depth;      // unsigned when in contact
    logic signed [15:0] r_dir [3];
    logic signed [63:0] r_push [3];
    logic signed [63:0] r_fr [3];
    logic               r_contact;

    logic [64:0] rt_try;
    logic [63:0] n_rem, n_root;
    logic signed [63:0] dsum;
    logic [47:0] rem_sh [3];

    assign o_stat.len_zero  = (r_root == 64'd0);
    assign o_stat.step_done = (r_cnt == 6'd1);
    assign o_contact = r_contact;

    // one root step on the remainder
    always_comb begin
        logic [63:0] bitv;
        bitv = 64'd1 << {r_cnt - 6'd1, 1'b0};
        rt_try = {1'b0, r_rem} - ({1'b0, r_root} + {1'b0, bitv});
        if (!rt_try[64]) begin
            n_rem  = rt_try[63:0];
            n_root = (r_root >> 1) + bitv;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
    end

    always_comb begin
        dsum = 64'(r_prod[0]) + 64'(r_prod[1]) + 64'(r_prod[2]);
        for (int k = 0; k < 3; k++)
            rem_sh[k] = {r_nrem[k], r_q[k][46]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_body[k] <= '0; r_bvel[k] <= '0; r_near[k] <= '0;
                r_deep_n[k] <= '0;
            end
            r_deep_d <= 32'sh80000000;
            r_deep_o <= '0;
            r_seen <= 1'b0;
            r_cnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_body[k] <= i_pos[k]; r_bvel[k] <= i_vel[k];
                        r_near[k] <= i_pos[k]; r_deep_n[k] <= '0;
                    end
                    r_deep_d <= 32'sh80000000; r_deep_o <= '0; r_seen <= 1'b0;
                end
                OP_PROD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= i_nrm[k];
                        r_prod[k] <= 48'(r_near[k] * i_nrm[k]);
                    end
                    r_off <= i_off;
                end
                OP_DIST: r_d <= sat32(rsh14(dsum) - 64'(r_off));
                OP_CPROD: begin
                    for (int k = 0; k < 3; k++)
                        r_prod[k] <= 48'(r_n[k] * r_d);
                end
                OP_UPD: begin
                    if (r_d > 0)
                        for (int k = 0; k < 3; k++)
                            r_near[k] <= sat32(64'(r_near[k]) - rsh14(64'(r_prod[k])));
                    if (!r_seen || r_d > r_deep_d) begin
                        r_seen <= 1'b1; r_deep_d <= r_d; r_deep_o <= r_off;
                        for (int k = 0; k < 3; k++) r_deep_n[k] <= r_n[k];
                    end
                end
                OP_DIFF: begin
                    for (int k = 0; k < 3; k++)
                        r_diff[k] <= sat32(64'(r_body[k]) - 64'(r_near[k]));
                end
                OP_SQ: begin
                    for (int k = 0; k < 3; k++)
                        r_sq[k] <= 64'(r_diff[k] * r_diff[k]);
                    r_cnt <= 6'(SQRT_STEPS);
                    r_root <= '0;
                end
                OP_SQRT: begin
                    if (i_cmd.first) r_rem <= r_sq[0] + r_sq[1] + r_sq[2];
                    else begin
                        r_rem <= n_rem; r_root <= n_root; r_cnt <= r_cnt - 6'd1;
                    end
                end
                OP_INP: begin
                    for (int k = 0; k < 3; k++) begin
                        r_prod[k] <= 48'(r_body[k] * r_deep_n[k]);
                        r_dir[k] <= r_deep_n[k];
                    end
                end
                OP_INS: r_lv <= 33'(sat32(rsh14(dsum) - 64'(r_deep_o)));
                OP_DIV: begin
                    if (i_cmd.first) begin
                        r_len <= r_root[31:0];
                        r_lv  <= $signed({1'b0, r_root[31:0]});
                        r_cnt <= 6'd47;
                        for (int k = 0; k < 3; k++) begin
                            r_nrem[k] <= '0;
                            r_q[k] <= {(r_diff[k][31] ? 33'(-64'(r_diff[k]))
                                                      : 33'(r_diff[k])), 14'd0};
                        end
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                        for (int k = 0; k < 3; k++) begin
                            if (rem_sh[k] >= {16'd0, r_len}) begin
                                r_nrem[k] <= 47'(rem_sh[k] - {16'd0, r_len});
                                r_q[k] <= {r_q[k][45:0], 1'b1};
                            end else begin
                                r_nrem[k] <= rem_sh[k][46:0];
                                r_q[k] <= {r_q[k][45:0], 1'b0};
                            end
                        end
                        if (r_cnt == 6'd1)
                            for (int k = 0; k < 3; k++) begin
                                logic [15:0] qq;
                                qq = (rem_sh[k] >= {16'd0, r_len}) ?
                                     {r_q[k][14:0], 1'b1} : {r_q[k][14:0], 1'b0};
                                r_dir[k] <= r_diff[k][31] ? -$signed(qq) : $signed(qq);
                            end
                    end
                end
                OP_DEPTH: begin
                    r_contact <= r_lv < $signed({2'b0, i_radius});
                    r_depth <= 48'(($signed({2'b0, i_radius}) - r_lv)
                                   * $signed({1'b0, i_stiff}));
                end
                OP_PUSH: begin
                    for (int k = 0; k < 3; k++) begin
                        r_push[k] <= 64'(r_dir[k] * $signed({1'b0, r_depth}));
                        r_fr[k] <= 64'(r_bvel[k] * $signed({1'b0, i_fric}));
                    end
                end
                OP_ACC: begin
                    for (int k = 0; k < 3; k++)
                        o_acc[k] <= r_contact ? sat32(rsh14(r_push[k]) - r_fr[k]) : '0;
                    o_ground <= r_contact && (r_deep_n[1] > $signed({1'b0, i_gthr}));
                    r_deep_d <= 32'sh80000000; r_deep_o <= '0; r_seen <= 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_near[k] <= r_body[k]; r_deep_n[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[tb/tb_contact_checker.sv]
// Result checker for the sphere/convex-block contact unit: watches all three channels,
// predicts each result from its own copy of the block state, compares field by field.
// Depends on scbc_pkg for register indexes and widths.
module tb_contact_checker
    import scbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [271:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    input  logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic               contact;
        logic               ground;
        logic signed [31:0] acc [3];
    } t_contact_result;

    t_contact_result contact_q [$];

    // mirrored registers
    logic [RADIUS_W-1:0] radius;
    logic [FRIC_W-1:0]   fric;
    logic [STIFF_W-1:0]  stiff;
    logic [GTHR_W-1:0]   gthr;

    // mirrored block state
    logic signed [31:0] body_pos [3];
    logic signed [31:0] body_vel [3];
    logic signed [31:0] near_pt  [3];
    logic signed [31:0] deep_dist;
    logic signed [15:0] deep_nrm [3];
    logic signed [31:0] deep_off;
    logic               wall_hit;
    int                 mismatches;

    assign o_pending = contact_q.size();

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] round14(input logic signed [63:0] x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] plane_dist(input logic signed [31:0] p [3],
                                                      input logic signed [15:0] n [3]);
        logic signed [63:0] s;
        s = 0;
        for (int i = 0; i < 3; i++) s = s + 64'(p[i]) * 64'(n[i]);
        return round14(s);
    endfunction

    task automatic clear_block();
        for (int i = 0; i < 3; i++) begin
            near_pt[i] = body_pos[i];
            deep_nrm[i] = '0;
        end
        deep_dist = 32'sh80000000;
        deep_off = '0;
        wall_hit = 1'b0;
    endtask

    // advance the mirrored state by one accepted item, queue a result on the last wall
    task automatic take_item(input logic [271:0] data, input logic func, input logic last);
        logic signed [15:0] n [3];
        logic signed [31:0] off, d;
        logic signed [31:0] diff [3];
        logic signed [63:0] lv, depth, acc, dir [3];
        logic [63:0] sum, len, a;
        t_contact_result r;
        if (!func) begin
            for (int i = 0; i < 3; i++) begin
                body_pos[i] = data[32*i +: 32];
                body_vel[i] = data[96 + 32*i +: 32];
            end
            clear_block();
            return;
        end
        for (int i = 0; i < 3; i++) n[i] = data[192 + 16*i +: 16];
        off = data[240 +: 32];
        d = clamp32(plane_dist(near_pt, n) - 64'(off));
        if (d > 0) begin
            for (int i = 0; i < 3; i++)
                near_pt[i] = clamp32(64'(near_pt[i]) - round14(64'(n[i]) * 64'(d)));
        end
        if (!wall_hit || d > deep_dist) begin
            wall_hit = 1'b1;
            deep_dist = d;
            deep_nrm = n;
            deep_off = off;
        end
        if (!last) return;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            diff[i] = clamp32(64'(body_pos[i]) - 64'(near_pt[i]));
            a = diff[i] < 0 ? 64'(-64'(diff[i])) : 64'(diff[i]);
            sum = sum + a * a;
        end
        len = floor_root(sum);
        if (len == 0) begin
            lv = clamp32(plane_dist(body_pos, deep_nrm) - 64'(deep_off));
            for (int i = 0; i < 3; i++) dir[i] = 64'(deep_nrm[i]);
        end else begin
            lv = $signed(len);
            for (int i = 0; i < 3; i++) dir[i] = (64'(diff[i]) * 64'sd16384) / $signed(len);
        end
        r.contact = 1'b0;
        r.ground = 1'b0;
        for (int i = 0; i < 3; i++) r.acc[i] = '0;
        if (lv < $signed({33'd0, radius})) begin
            r.contact = 1'b1;
            r.ground = $signed({16'd0, deep_nrm[1]}) > 0 && 32'(deep_nrm[1]) > 32'(gthr)
                       && !deep_nrm[1][15];
            depth = ($signed({33'd0, radius}) - lv) * $signed({48'd0, stiff});
            for (int i = 0; i < 3; i++) begin
                acc = round14(dir[i] * depth) - 64'(body_vel[i]) * $signed({54'd0, fric});
                r.acc[i] = clamp32(acc);
            end
        end
        contact_q.push_back(r);
        clear_block();
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    initial begin
        o_fail_count = 0;
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        t_contact_result w;
        if (!i_rst_n) begin
            radius = RADIUS_RST;
            fric = FRIC_RST;
            stiff = STIFF_RST;
            gthr = GTHR_RST;
            for (int i = 0; i < 3; i++) begin
                body_pos[i] = '0;
                body_vel[i] = '0;
            end
            clear_block();
        end else begin
            // compare a result transfer with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (contact_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
                end else begin
                    w = contact_q.pop_front();
                    if (m_axis_tuser !== w.contact) report("contact", 32'(w.contact),
                                                           32'(m_axis_tuser));
                    if (m_axis_tdata[0] !== w.ground) report("grounded", 32'(w.ground),
                                                             32'(m_axis_tdata[0]));
                    for (int i = 0; i < 3; i++)
                        if (m_axis_tdata[1 + 32*i +: 32] !== w.acc[i])
                            report($sformatf("accel[%0d]", i), w.acc[i],
                                   m_axis_tdata[1 + 32*i +: 32]);
                    if (m_axis_tdata[103:97] !== '0)
                        report("fill", 32'd0, 32'(m_axis_tdata[103:97]));
                end
            end
            // mirror register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIUS: radius = i_cfg_data[RADIUS_W-1:0];
                    REG_FRIC:   fric = i_cfg_data[FRIC_W-1:0];
                    REG_STIFF:  stiff = i_cfg_data[STIFF_W-1:0];
                    default:    gthr = i_cfg_data[GTHR_W-1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            o_fail_count <= mismatches;
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the sphere/convex-block contact unit: clock, reset, stimulus, verdict.
// Depends on scbc_pkg, sphere_convex_block_contact and tb_contact_checker.
module tb_top
    import scbc_pkg::*;
();

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [271:0] s_data = '0;
    logic         s_last = 1'b0;
    logic         s_user = 1'b0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [103:0] m_data;
    logic         m_user;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    int           fail_count;
    int           pending;
    int           items_sent = 0;
    int           idle_cycles = 0;
    logic         hold_request = 1'b0;
    logic         no_gaps = 1'b0;

    sphere_convex_block_contact uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .s_axis_tlast(s_last), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    tb_contact_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .s_axis_tlast(s_last), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 4000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int w;
        int fast;
        fast = 0;
        @(posedge i_clk iff i_rst_n);
        m_ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(m_valid && m_ready));
            if (fast > 0) fast--;
            else if ($urandom_range(0, 15) == 0) fast = 20;
            w = fast > 0 ? 0 : $urandom_range(0, 9);
            if (hold_request) begin
                hold_request = 1'b0;
                w = 400;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [15:0] pick_normal();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return '0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // offer one item; valid stays high after the transfer so a back-to-back item
    // follows without a gap, and drops here or in drain otherwise
    task automatic send_item(input logic func, input logic [271:0] data, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= data;
        s_user <= func;
        s_last <= last;
        do @(posedge i_clk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    task automatic send_load(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz);
        send_item(1'b0, {80'd0, vz, vy, vx, pz, py, px}, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_wall(input logic [15:0] nx, input logic [15:0] ny,
                             input logic [15:0] nz, input logic [31:0] off,
                             input logic last);
        send_item(1'b1, {off, nz, ny, nx, 192'd0}, last);
    endtask

    // valid stays high for a following write and is dropped by the caller
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
    endtask

    // drop valid, wait for every result, then let a last wall finish
    task automatic drain();
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (150) @(posedge i_clk);
    endtask

    // one block near the body, or random noise
    task automatic random_block();
        logic signed [31:0] p [3];
        logic signed [15:0] n [3];
        logic signed [63:0] dot;
        int walls;
        no_gaps = ($urandom_range(0, 3) == 0);
        walls = $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0) begin
            send_load(pick32(), pick32(), pick32(), pick32(), pick32(), pick32());
            for (int k = 0; k < walls; k++)
                send_wall(pick_normal(), pick_normal(), pick_normal(), pick32(),
                          k == walls - 1 || $urandom_range(0, 7) == 0);
            return;
        end
        for (int i = 0; i < 3; i++) p[i] = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        send_load(p[0], p[1], p[2], pick32() >>> $urandom_range(0, 20),
                  pick32() >>> $urandom_range(0, 20), pick32() >>> $urandom_range(0, 20));
        for (int k = 0; k < walls; k++) begin
            for (int i = 0; i < 3; i++) n[i] = '0;
            if ($urandom_range(0, 1)) n[$urandom_range(0, 2)] = $urandom_range(0, 1) ?
                                                                16'sd16384 : -16'sd16384;
            else for (int i = 0; i < 3; i++) n[i] = pick_normal();
            dot = 0;
            for (int i = 0; i < 3; i++) dot = dot + 64'(p[i]) * 64'(n[i]);
            send_wall(n[0], n[1], n[2],
                      32'((dot >>> 14) + $signed($urandom_range(0, 262144)) - 131072),
                      k == walls - 1);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wall before any load (body inside, ground normal)
        send_wall(16'sd0, 16'sd16384, 16'sd0, 32'd0, 1'b1);
        // extreme offsets and normals from the origin
        send_load(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_wall(16'sd16384, 16'sd0, 16'sd0, 32'h80000000, 1'b0);
        send_wall(-16'sd16384, -16'sd16384, -16'sd16384, 32'h7fffffff, 1'b1);
        // extreme body fields, no contact far from a wall
        send_load(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000);
        send_wall(16'sd16384, 16'sd0, 16'sd0, 32'd0, 1'b1);
        // body inside a box: deepest wall decides
        send_load(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'hffff_0000, 32'd5);
        send_wall(16'sd16384, 16'sd0, 16'sd0, 32'h0002_0000, 1'b0);
        send_wall(-16'sd16384, 16'sd0, 16'sd0, 32'h0002_0000, 1'b0);
        send_wall(16'sd0, 16'sd16384, 16'sd0, 32'h0000_8000, 1'b0);
        send_wall(16'sd0, -16'sd16384, 16'sd0, 32'h0002_0000, 1'b0);
        send_wall(16'sd0, 16'sd0, 16'sd16384, 32'h0002_0000, 1'b0);
        send_wall(16'sd0, 16'sd0, -16'sd16384, 32'h0002_0000, 1'b1);
        // body just above a floor: contact and ground
        send_load(32'd0, 32'h0000_8000, 32'd0, 32'd0, 32'hfff0_0000, 32'd0);
        send_wall(16'sd0, 16'sd16384, 16'sd0, 32'd0, 1'b1);
        // body beside a wall with a tilted, non-unit normal
        send_load(32'h0000_4000, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0, 32'd0);
        send_wall(16'sd11585, 16'sd11585, 16'sd300, 32'd0, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_RADIUS, 32'hffff_ffff);
                    write_reg(REG_FRIC, 32'h3ff);
                    write_reg(REG_STIFF, 32'hffff);
                    write_reg(REG_GTHR, 32'd16384);
                end
                1: begin
                    write_reg(REG_RADIUS, 32'd0);
                    write_reg(REG_FRIC, 32'd0);
                    write_reg(REG_STIFF, 32'd0);
                    write_reg(REG_GTHR, 32'd0);
                end
                2: begin
                    write_reg(REG_RADIUS, $urandom_range(1 << 15, 1 << 19));
                    write_reg(REG_FRIC, $urandom_range(0, 1023));
                    write_reg(REG_STIFF, $urandom_range(0, 65535));
                    write_reg(REG_GTHR, $urandom_range(0, 16384));
                    hold_request = 1'b1;
                end
                default: begin
                    write_reg(REG_RADIUS, 32'(RADIUS_RST));
                    write_reg(REG_FRIC, 32'(FRIC_RST));
                    write_reg(REG_STIFF, 32'(STIFF_RST));
                    write_reg(REG_GTHR, 32'(GTHR_RST));
                end
            endcase
            cfg_valid <= 1'b0;
            while (items_sent < 20 + 400 * (ph + 1))
                random_block();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sphere_convex_block_contact.f]
sv/scbc_pkg.sv
sv/scbc_ctrl.sv
sv/scbc_dp.sv
sv/sphere_convex_block_contact.sv
tb/tb_contact_checker.sv
tb/tb_top.sv
